// File: design/tfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetrahedron face deduplication table: shared definitions
// Widths, table geometry and the types that pass between the modules.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam int VERTEX_W       = 12;
    localparam int VERTEX_COUNT   = 2 ** VERTEX_W;
    localparam int BUCKET_SLOTS   = 16;
    localparam int SLOT_W         = $clog2(BUCKET_SLOTS);
    localparam int FILL_W         = $clog2(BUCKET_SLOTS + 1);
    localparam int TRIANGLE_LIMIT = 65536;
    localparam int COUNT_W        = $clog2(TRIANGLE_LIMIT + 1);
    localparam int ID_W           = 16;
    localparam int FACES          = 4;
    localparam int FACE_W         = $clog2(FACES);

    typedef logic [VERTEX_W-1:0] vertex_t;

    typedef struct packed {
        vertex_t           mid;
        vertex_t           high;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef entry_t [BUCKET_SLOTS-1:0] row_t;

    typedef struct packed {
        vertex_t lo;
        vertex_t mi;
        vertex_t hi;
    } face_t;

    typedef struct packed {
        logic    en;
        vertex_t addr;
    } bucket_rd_t;

    typedef struct packed {
        logic              en;
        vertex_t           addr;
        logic [FILL_W-1:0] fill;
        row_t              row;
    } bucket_wr_t;

    function automatic face_t sort3(vertex_t a, vertex_t b, vertex_t c);
        vertex_t x;
        vertex_t y;
        vertex_t z;
        vertex_t t;
        face_t   f;
        x = a;
        y = b;
        z = c;
        if (x > y)
        begin
            t = x;
            x = y;
            y = t;
        end
        if (y > z)
        begin
            t = y;
            y = z;
            z = t;
        end
        if (x > y)
        begin
            t = x;
            x = y;
            y = t;
        end
        f.lo = x;
        f.mi = y;
        f.hi = z;
        return f;
    endfunction

endpackage

// File: design/tfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetrahedron face deduplication table: channel interfaces
// Valid/ready channels for the tetrahedron input and the face results.
// ----------------------------------------------------------------------------
interface tfd_tetra_if;
    logic            valid;
    logic            ready;
    tfd_pkg::vertex_t corner_a;
    tfd_pkg::vertex_t corner_b;
    tfd_pkg::vertex_t corner_c;
    tfd_pkg::vertex_t corner_d;

    modport source (output valid, output corner_a, output corner_b,
                    output corner_c, output corner_d, input ready);
    modport sink   (input valid, input corner_a, input corner_b,
                    input corner_c, input corner_d, output ready);
endinterface

interface tfd_face_if;
    logic                          valid;
    logic                          ready;
    logic [tfd_pkg::FACE_W-1:0]    face_slot;
    logic [tfd_pkg::ID_W-1:0]      triangle_id;
    logic                          is_new;
    tfd_pkg::vertex_t              low_vertex;
    tfd_pkg::vertex_t              mid_vertex;
    tfd_pkg::vertex_t              high_vertex;
    logic                          overflow;
    logic                          last_face;

    modport source (output valid, output face_slot, output triangle_id,
                    output is_new, output low_vertex, output mid_vertex,
                    output high_vertex, output overflow, output last_face,
                    input ready);
    modport sink   (input valid, input face_slot, input triangle_id,
                    input is_new, input low_vertex, input mid_vertex,
                    input high_vertex, input overflow, input last_face,
                    output ready);
endinterface

// File: design/tetra_face_dedup_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetrahedron face deduplication table
// Turns each tetrahedron into four deduplicated triangle ids.
// ----------------------------------------------------------------------------
// The tetra channel takes one tetrahedron per transaction, four vertex ids.
// The face channel returns four transactions per tetrahedron, faces zero to
// three in order, the fourth marked with last_face. Each face is sorted and
// looked up in the bucket of its lowest vertex; a hit returns the stored id,
// a miss appends an entry with the next id from a running counter. A miss
// in a full bucket, or once the id space is used up, returns overflow.
// A tetrahedron is accepted in the idle state; each face then takes a read
// of the fill-count and bucket-row memories followed by the compare and
// write back, and its result is registered in the output register. After
// reset the fill counts are cleared, one bucket per cycle; tetra.ready stays
// low until that pass has finished.
// A stall on the face channel holds the current result and pauses the
// lookup of the next face; no tetrahedron is taken until the fourth face of
// the previous one has been looked up, though that face may still wait in
// the output register.
// ----------------------------------------------------------------------------
module tetra_face_dedup_table (
    input  logic        clk,
    input  logic        rst_n,
    tfd_tetra_if.sink   tetra,
    tfd_face_if.source  face
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_ISSUE   = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [tfd_pkg::FACE_W-1:0]   slot_reg;
    logic [tfd_pkg::FACE_W-1:0]   slot_next;
    logic [tfd_pkg::COUNT_W-1:0]  count_reg;
    logic [tfd_pkg::COUNT_W-1:0]  count_next;
    tfd_pkg::vertex_t             corner_reg [tfd_pkg::FACES];
    tfd_pkg::face_t               face_reg;
    tfd_pkg::face_t               sorted;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [tfd_pkg::FACE_W-1:0]   out_slot_reg;
    logic [tfd_pkg::ID_W-1:0]     out_id_reg;
    logic                         out_new_reg;
    tfd_pkg::face_t               out_face_reg;
    logic                         out_over_reg;
    logic                         out_last_reg;

    tfd_pkg::bucket_rd_t          rd_req;
    tfd_pkg::bucket_wr_t          wr_req;
    logic [tfd_pkg::FILL_W-1:0]   rd_fill;
    tfd_pkg::row_t                rd_row;
    logic                         busy;

    logic                         in_fire;
    logic                         resolve_fire;
    logic                         hit;
    logic [tfd_pkg::ID_W-1:0]     hit_id;
    logic                         full;
    logic                         exhausted;
    logic                         over;
    logic                         fresh;
    logic [tfd_pkg::ID_W-1:0]     result_id;
    tfd_pkg::row_t                row_new;

    tfd_bucket_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd_req),
        .wr      (wr_req),
        .rd_fill (rd_fill),
        .rd_row  (rd_row),
        .busy    (busy)
    );

    assign tetra.ready  = (state_reg == ST_IDLE) && !busy;
    assign in_fire      = tetra.valid && tetra.ready;
    assign resolve_fire = (state_reg == ST_RESOLVE) && (!out_valid_reg || face.ready);

    assign sorted = tfd_pkg::sort3(corner_reg[slot_reg],
                                   corner_reg[slot_reg + tfd_pkg::FACE_W'(1)],
                                   corner_reg[slot_reg + tfd_pkg::FACE_W'(2)]);

    assign rd_req.en   = (state_reg == ST_ISSUE);
    assign rd_req.addr = sorted.lo;

    // The first matching slot below the fill count wins.
    always_comb
    begin
        hit    = 1'b0;
        hit_id = '0;
        for (int s = tfd_pkg::BUCKET_SLOTS - 1; s >= 0; s--)
        begin
            if ((tfd_pkg::FILL_W'(s) < rd_fill) && (rd_row[s].mid == face_reg.mi) &&
                (rd_row[s].high == face_reg.hi))
            begin
                hit    = 1'b1;
                hit_id = rd_row[s].id;
            end
        end
    end

    assign full      = (rd_fill >= tfd_pkg::FILL_W'(tfd_pkg::BUCKET_SLOTS));
    assign exhausted = (count_reg >= tfd_pkg::COUNT_W'(tfd_pkg::TRIANGLE_LIMIT));
    assign over      = !hit && (full || exhausted);
    assign fresh     = !hit && !over;

    always_comb
    begin
        priority if (hit)
        begin
            result_id = hit_id;
        end
        else if (fresh)
        begin
            result_id = count_reg[tfd_pkg::ID_W-1:0];
        end
        else
        begin
            result_id = '0;
        end
    end

    always_comb
    begin
        row_new = rd_row;
        row_new[rd_fill[tfd_pkg::SLOT_W-1:0]].mid  = face_reg.mi;
        row_new[rd_fill[tfd_pkg::SLOT_W-1:0]].high = face_reg.hi;
        row_new[rd_fill[tfd_pkg::SLOT_W-1:0]].id   = count_reg[tfd_pkg::ID_W-1:0];
    end

    assign wr_req.en   = resolve_fire && fresh;
    assign wr_req.addr = face_reg.lo;
    assign wr_req.fill = rd_fill + tfd_pkg::FILL_W'(1);
    assign wr_req.row  = row_new;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !face.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    slot_next  = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (resolve_fire)
                begin
                    out_valid_next = 1'b1;
                    if (fresh)
                    begin
                        count_next = count_reg + tfd_pkg::COUNT_W'(1);
                    end
                    if (slot_reg == tfd_pkg::FACE_W'(tfd_pkg::FACES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + tfd_pkg::FACE_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            corner_reg[0] <= tetra.corner_a;
            corner_reg[1] <= tetra.corner_b;
            corner_reg[2] <= tetra.corner_c;
            corner_reg[3] <= tetra.corner_d;
        end
        if (state_reg == ST_ISSUE)
        begin
            face_reg <= sorted;
        end
        if (resolve_fire)
        begin
            out_slot_reg <= slot_reg;
            out_id_reg   <= result_id;
            out_new_reg  <= fresh;
            out_face_reg <= face_reg;
            out_over_reg <= over;
            out_last_reg <= (slot_reg == tfd_pkg::FACE_W'(tfd_pkg::FACES - 1));
        end
    end

    assign face.valid       = out_valid_reg;
    assign face.face_slot   = out_slot_reg;
    assign face.triangle_id = out_id_reg;
    assign face.is_new      = out_new_reg;
    assign face.low_vertex  = out_face_reg.lo;
    assign face.mid_vertex  = out_face_reg.mi;
    assign face.high_vertex = out_face_reg.hi;
    assign face.overflow    = out_over_reg;
    assign face.last_face   = out_last_reg;

endmodule

// File: design/tfd_bucket_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetrahedron face deduplication table: bucket store
// Fill-count memory and bucket-row memory, one registered read port and
// one write port each, with a clearing pass over the fill counts after reset.
// ----------------------------------------------------------------------------
module tfd_bucket_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tfd_pkg::bucket_rd_t         rd,
    input  tfd_pkg::bucket_wr_t         wr,
    output logic [tfd_pkg::FILL_W-1:0]  rd_fill,
    output tfd_pkg::row_t               rd_row,
    output logic                        busy
);

    logic [tfd_pkg::FILL_W-1:0] fill_mem [tfd_pkg::VERTEX_COUNT];
    tfd_pkg::row_t              entry_mem [tfd_pkg::VERTEX_COUNT];

    logic                       clear_reg;
    logic                       clear_next;
    tfd_pkg::vertex_t           clear_addr_reg;
    tfd_pkg::vertex_t           clear_addr_next;
    logic [tfd_pkg::FILL_W-1:0] fill_q_reg;
    tfd_pkg::row_t              row_q_reg;

    always_comb
    begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg)
        begin
            clear_addr_next = clear_addr_reg + tfd_pkg::vertex_t'(1);
            if (clear_addr_reg == {tfd_pkg::VERTEX_W{1'b1}})
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            fill_mem[clear_addr_reg] <= '0;
        end
        else if (wr.en)
        begin
            fill_mem[wr.addr] <= wr.fill;
        end
        if (rd.en)
        begin
            fill_q_reg <= fill_mem[rd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_mem[wr.addr] <= wr.row;
        end
        if (rd.en)
        begin
            row_q_reg <= entry_mem[rd.addr];
        end
    end

    assign rd_fill = fill_q_reg;
    assign rd_row  = row_q_reg;
    assign busy    = clear_reg;

endmodule

// File: design/tfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetrahedron face deduplication table: port checker
// Concurrent assertions on the face channel, bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [tfd_pkg::FACE_W-1:0] face_slot,
    input logic [tfd_pkg::ID_W-1:0]   triangle_id,
    input logic                       is_new,
    input tfd_pkg::vertex_t           low_vertex,
    input tfd_pkg::vertex_t           mid_vertex,
    input tfd_pkg::vertex_t           high_vertex,
    input logic                       overflow,
    input logic                       last_face
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("face transaction dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(triangle_id) && $stable(face_slot))
        else $error("face payload changed while stalled");

    a_last_marks_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_face == (face_slot == tfd_pkg::FACE_W'(tfd_pkg::FACES - 1))))
        else $error("last_face does not match the fourth face");

    a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (triangle_id == '0) && !is_new)
        else $error("overflow result carries an id or a new mark");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (low_vertex <= mid_vertex) && (mid_vertex <= high_vertex))
        else $error("face vertices are not sorted");

endmodule

bind tetra_face_dedup_table tfd_checker u_tfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (face.valid),
    .out_ready   (face.ready),
    .face_slot   (face.face_slot),
    .triangle_id (face.triangle_id),
    .is_new      (face.is_new),
    .low_vertex  (face.low_vertex),
    .mid_vertex  (face.mid_vertex),
    .high_vertex (face.high_vertex),
    .overflow    (face.overflow),
    .last_face   (face.last_face)
);
